// File: src/assert_macros.svh
// Assertion macros used by the output buffer RTL of the score byte parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, ignored while reset is asserted.
`define SEB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the house clock and reset names.
`define SEB_ASSERT(label, prop, msg) \
  `SEB_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: src/seb_pkg.sv
// Types, opcodes and length decode shared by the score byte parser.
`timescale 1ns / 1ps
`default_nettype none

package seb_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 32;
  localparam int unsigned GATHER_DEPTH      = 6;

  localparam logic [7:0] NOTE_MAX       = 8'h7F;
  localparam logic [7:0] OP_END         = 8'h80;
  localparam logic [7:0] OP_UNK_81      = 8'h81;
  localparam logic [7:0] OP_UNK_82      = 8'h82;
  localparam logic [7:0] OP_PROGRAM     = 8'h83;
  localparam logic [7:0] OP_BEND        = 8'h84;
  localparam logic [7:0] OP_VOLUME      = 8'h85;
  localparam logic [7:0] OP_EXPRESSION  = 8'h86;
  localparam logic [7:0] OP_PAN         = 8'h87;
  localparam logic [7:0] OP_UNK_88      = 8'h88;
  localparam logic [7:0] OP_SUSTAIN     = 8'h89;
  localparam logic [7:0] OP_UNK_8A      = 8'h8A;
  localparam logic [7:0] OP_SEGNO_START = 8'h8D;
  localparam logic [7:0] OP_SEGNO_END   = 8'h8E;
  localparam logic [7:0] OP_REST        = 8'h8F;
  localparam logic [7:0] OP_UNK_90      = 8'h90;
  localparam logic [7:0] OP_UNK_92      = 8'h92;
  localparam logic [7:0] OP_UNK_93      = 8'h93;
  localparam logic [7:0] OP_UNK_94      = 8'h94;
  localparam logic [7:0] OP_UNK_95      = 8'h95;
  localparam logic [7:0] OP_BEND_RANGE  = 8'h96;
  localparam logic [7:0] OP_UNK_97      = 8'h97;
  localparam logic [7:0] OP_UNK_99      = 8'h99;
  localparam logic [7:0] OP_UNK_9A      = 8'h9A;
  localparam logic [7:0] OP_UNK_9B      = 8'h9B;
  localparam logic [7:0] OP_IMPLY       = 8'h9E;

  localparam logic [15:0] BEND_RANGE_CENTS = 16'd100;

  typedef enum logic [3:0] {
    KIND_NOTE        = 4'd0,
    KIND_PROGRAM     = 4'd1,
    KIND_BEND        = 4'd2,
    KIND_VOLUME      = 4'd3,
    KIND_EXPRESSION  = 4'd4,
    KIND_PAN         = 4'd5,
    KIND_SUSTAIN     = 4'd6,
    KIND_BEND_RANGE  = 4'd7,
    KIND_REST        = 4'd8,
    KIND_SEGNO_START = 4'd9,
    KIND_SEGNO_END   = 4'd10,
    KIND_IMPLY       = 4'd11,
    KIND_UNKNOWN     = 4'd12,
    KIND_END         = 4'd13,
    KIND_BAD         = 4'd14
  } event_kind_e;

  typedef enum logic {
    PHASE_WAIT,
    PHASE_GATHER
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       pattern_start;
  } in_item_t;

  typedef struct packed {
    event_kind_e        event_kind;
    logic [6:0]         key;
    logic [7:0]         velocity;
    logic [7:0]         note_length;
    logic [7:0]         delta_ticks;
    logic signed [15:0] event_value;
    logic [7:0]         bank_number;
    logic [2:0]         event_bytes;
    logic [31:0]        event_time;
  } out_item_t;

  // Bytes that follow a status byte; notes drop the fields that are implied.
  function automatic logic [2:0] trailing_count(input logic [7:0] op,
                                                input logic       len_implied,
                                                input logic       vel_implied);
    logic [2:0] n;
    n = 3'd0;
    if (op <= NOTE_MAX) begin
      n = 3'd1 + 3'(!len_implied) + 3'(!vel_implied);
    end else begin
      unique case (op)
        OP_UNK_81, OP_UNK_82, OP_BEND, OP_VOLUME, OP_EXPRESSION, OP_PAN,
        OP_UNK_88, OP_SUSTAIN, OP_UNK_8A, OP_UNK_90, OP_UNK_92, OP_UNK_93,
        OP_UNK_95, OP_BEND_RANGE, OP_UNK_99, OP_UNK_9A, OP_IMPLY: n = 3'd2;
        OP_PROGRAM:                n = 3'd3;
        OP_SEGNO_END, OP_REST:     n = 3'd1;
        OP_UNK_94:                 n = 3'd4;
        OP_UNK_97:                 n = 3'd5;
        OP_UNK_9B:                 n = 3'd6;
        default:                   n = 3'd0;
      endcase
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/sequence_event_byte_parser.sv
// Each decoded event is registered in the output register, or in the skid entry.
// Throughput: one byte per cycle; the decode is a single pass between the parser
// state registers and the output register, and a one-entry skid takes a result
// while the output waits, so input stalls only when both are full.
// Reset: asynchronous, active low; clears the parser, implied values, running time
// and stop flag, and empties the output buffer.
`timescale 1ns / 1ps
`default_nettype none

module sequence_event_byte_parser #(
  parameter int unsigned TIME_BITS = seb_pkg::TIME_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input request channel: one score byte per request
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  seb_pkg::in_item_t  in_data_i,
  // output request channel: one decoded event per request
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output seb_pkg::out_item_t out_data_o
);
  import seb_pkg::*;

  logic      accept;
  logic      res_valid;
  logic      buf_full;
  out_item_t res;

  // Stall only while the skid entry holds a result; stall is a register output.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  // Decode each accepted request and advance the parser state.
  seb_parser #(
    .TIME_BITS(TIME_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Hold finished events until the consumer takes them.
  seb_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .data_i     (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: src/seb_parser.sv
// Parser state and single-pass event decode for the score byte parser.
`timescale 1ns / 1ps
`default_nettype none

module seb_parser #(
  parameter int unsigned TIME_BITS = seb_pkg::TIME_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  seb_pkg::in_item_t item_i,
  output logic              res_valid_o,
  output seb_pkg::out_item_t res_o
);
  import seb_pkg::*;

  parse_phase_e         phase_q, phase_d;
  logic [7:0]           opcode_q, opcode_d;
  logic [7:0]           gath_q [GATHER_DEPTH];
  logic [7:0]           gath_d [GATHER_DEPTH];
  logic [7:0]           g_eff  [GATHER_DEPTH];
  logic [2:0]           remain_q, remain_d;
  logic [7:0]           imp_len_q, imp_len_d;
  logic [7:0]           imp_vel_q, imp_vel_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 finished_q, finished_d;

  logic                 start;
  logic [7:0]           in_byte;
  logic [7:0]           il, iv;
  logic                 fin_eff;
  parse_phase_e         ph_eff;
  logic [2:0]           n_cur, n_status, n_fin, idx;
  logic [7:0]           fin_op;
  logic                 set_stop, set_imply;
  logic [63:0]          time_ext;
  out_item_t            ev;

  // Pattern start overrides the held state before the byte is looked at.
  always_comb begin
    start    = item_i.pattern_start;
    in_byte  = item_i.byte_in;
    il       = start ? 8'd0 : imp_len_q;
    iv       = start ? 8'd0 : imp_vel_q;
    fin_eff  = start ? 1'b0 : finished_q;
    ph_eff   = start ? PHASE_WAIT : phase_q;
    n_cur    = trailing_count(opcode_q, il != 8'd0, iv != 8'd0);
    n_status = trailing_count(in_byte, il != 8'd0, iv != 8'd0);
    idx      = n_cur - remain_q;
    fin_op   = (ph_eff == PHASE_WAIT) ? in_byte : opcode_q;
    n_fin    = trailing_count(fin_op, il != 8'd0, iv != 8'd0);
    time_ext = 64'(time_q);
    for (int k = 0; k < GATHER_DEPTH; k++) begin
      g_eff[k] = ((ph_eff == PHASE_GATHER) && (idx == 3'(k))) ? in_byte : gath_q[k];
    end
  end

  // Event decode from the opcode and the gathered bytes, newest byte merged in.
  always_comb begin
    ev             = '0;
    ev.event_kind  = KIND_UNKNOWN;
    ev.event_bytes = n_fin + 3'd1;
    ev.event_time  = time_ext[31:0];
    set_stop       = 1'b0;
    set_imply      = 1'b0;
    if (fin_op <= NOTE_MAX) begin
      ev.event_kind  = KIND_NOTE;
      ev.key         = fin_op[6:0];
      ev.delta_ticks = g_eff[0];
      ev.note_length = (il != 8'd0) ? il : g_eff[1];
      if (iv != 8'd0) begin
        ev.velocity = iv;
      end else begin
        ev.velocity = (il != 8'd0) ? g_eff[1] : g_eff[2];
      end
    end else begin
      unique case (fin_op)
        OP_END: begin
          ev.event_kind = KIND_END;
          set_stop      = 1'b1;
        end
        OP_PROGRAM: begin
          ev.event_kind  = KIND_PROGRAM;
          ev.delta_ticks = g_eff[0];
          ev.event_value = {9'd0, g_eff[1][6:0]};
          ev.bank_number = {g_eff[2][6:0], g_eff[1][7]};
        end
        OP_BEND: begin
          ev.event_kind  = KIND_BEND;
          ev.delta_ticks = g_eff[0];
          ev.event_value = {g_eff[1][7], g_eff[1], 7'd0};
        end
        OP_VOLUME, OP_EXPRESSION, OP_PAN, OP_SUSTAIN: begin
          unique case (fin_op)
            OP_VOLUME:     ev.event_kind = KIND_VOLUME;
            OP_EXPRESSION: ev.event_kind = KIND_EXPRESSION;
            OP_PAN:        ev.event_kind = KIND_PAN;
            default:       ev.event_kind = KIND_SUSTAIN;
          endcase
          ev.delta_ticks = g_eff[0];
          ev.event_value = {8'd0, g_eff[1]};
        end
        OP_BEND_RANGE: begin
          ev.event_kind  = KIND_BEND_RANGE;
          ev.delta_ticks = g_eff[0];
          ev.event_value = 16'({8'd0, g_eff[1]} * BEND_RANGE_CENTS);
        end
        OP_REST: begin
          ev.event_kind  = KIND_REST;
          ev.delta_ticks = g_eff[0];
        end
        OP_SEGNO_START: ev.event_kind = KIND_SEGNO_START;
        OP_SEGNO_END:   ev.event_kind = KIND_SEGNO_END;
        OP_IMPLY: begin
          ev.event_kind  = KIND_IMPLY;
          ev.note_length = g_eff[0];
          ev.velocity    = g_eff[1];
          set_imply      = 1'b1;
        end
        OP_UNK_81, OP_UNK_82, OP_UNK_88, OP_UNK_8A, OP_UNK_90, OP_UNK_92,
        OP_UNK_93, OP_UNK_94, OP_UNK_95, OP_UNK_97, OP_UNK_99, OP_UNK_9A,
        OP_UNK_9B: begin
          ev.event_kind  = KIND_UNKNOWN;
          ev.delta_ticks = g_eff[0];
        end
        default: begin
          ev.event_kind = KIND_BAD;
          set_stop      = 1'b1;
        end
      endcase
    end
  end

  // Advance the parser on every accepted byte.
  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    gath_d      = gath_q;
    remain_d    = remain_q;
    imp_len_d   = imp_len_q;
    imp_vel_d   = imp_vel_q;
    time_d      = time_q;
    finished_d  = finished_q;
    res_valid_o = 1'b0;
    if (accept_i) begin
      imp_len_d  = il;
      imp_vel_d  = iv;
      finished_d = fin_eff;
      phase_d    = ph_eff;
      remain_d   = start ? 3'd0 : remain_q;
      if (!fin_eff) begin
        if (ph_eff == PHASE_WAIT) begin
          opcode_d = in_byte;
          if (n_status == 3'd0) begin
            res_valid_o = 1'b1;
          end else begin
            remain_d = n_status;
            phase_d  = PHASE_GATHER;
          end
        end else begin
          for (int k = 0; k < GATHER_DEPTH; k++) begin
            if (idx == 3'(k)) begin
              gath_d[k] = in_byte;
            end
          end
          remain_d = remain_q - 3'd1;
          if (remain_q == 3'd1) begin
            res_valid_o = 1'b1;
          end
        end
      end
      if (res_valid_o) begin
        phase_d  = PHASE_WAIT;
        remain_d = 3'd0;
        time_d   = time_q + TIME_BITS'(ev.delta_ticks);
        if (set_stop) begin
          finished_d = 1'b1;
        end
        if (set_imply) begin
          imp_len_d = g_eff[0];
          imp_vel_d = g_eff[1];
        end
      end
    end
  end

  assign res_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PHASE_WAIT;
      opcode_q   <= 8'd0;
      remain_q   <= 3'd0;
      imp_len_q  <= 8'd0;
      imp_vel_q  <= 8'd0;
      time_q     <= '0;
      finished_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      remain_q   <= remain_d;
      imp_len_q  <= imp_len_d;
      imp_vel_q  <= imp_vel_d;
      time_q     <= time_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gath_q <= gath_d;
  end

endmodule

`default_nettype wire

// File: src/seb_out_buf.sv
// Output register with one skid entry for the score byte parser results.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module seb_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  seb_pkg::out_item_t data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output seb_pkg::out_item_t out_data_o
);
  import seb_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SEB_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `SEB_ASSERT(a_no_push_when_full, push_i |-> !skid_valid_q, "result pushed into full buffer")
  `SEB_ASSERT(a_stalled_holds, out_valid_q && out_stall_i |=> out_valid_q, "stalled result dropped")

endmodule

`default_nettype wire
